// ----- rtl/sshp_pkg.sv -----
// ----------------------------------------------------------------------------
// sshp_pkg
// Shared types, constants and helpers for the strand-shift Hamming profile.
// ----------------------------------------------------------------------------
package sshp_pkg;

  localparam int MAX_STEPS   = 512;
  localparam int COUNT_WIDTH = 32;

  localparam int IDX_W   = $clog2(MAX_STEPS);
  localparam int LEN_W   = 10;
  localparam int RL_W    = 8;
  localparam int SIDX_W  = 9;
  localparam int OUT_W   = 32;
  localparam int CFG_W   = 10;
  localparam int POS_W   = (IDX_W + 2 > LEN_W + 1) ? IDX_W + 2 : LEN_W + 1;

  typedef enum logic [2:0] {
    OP_SAMPLE    = 3'd0,
    OP_NEW_CHROM = 3'd1,
    OP_REPORT    = 3'd2,
    OP_READ      = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  localparam logic CFG_STEPS_USED = 1'b0;
  localparam logic CFG_READ_LEN   = 1'b1;

  typedef struct packed {
    logic sample;
    logic rev;
    logic clr_line;
    logic clr_count;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] last;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] pend;
    logic [POS_W-1:0] read_idx;
  } scan_ctrl_t;

  typedef struct packed {
    logic [IDX_W-1:0]       fi;
    logic [IDX_W-1:0]       pi;
    logic [COUNT_WIDTH-1:0] fmin;
    logic [COUNT_WIDTH-1:0] fmax;
    logic [COUNT_WIDTH-1:0] pmin;
    logic [COUNT_WIDTH-1:0] curve;
  } scan_res_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+OUT_W-1:0] ext;
    logic [COUNT_WIDTH+OUT_W-1:0] hi;
    ext = {{OUT_W{1'b0}}, v};
    hi  = ext >> OUT_W;
    if (hi != '0) begin
      return '1;
    end
    return ext[OUT_W-1:0];
  endfunction

endpackage

// ----- rtl/sshp_cell.sv -----
// ----------------------------------------------------------------------------
// sshp_cell
// One shift cell: a forward delay bit and a saturating distance counter.
// ----------------------------------------------------------------------------
module sshp_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  sshp_pkg::cell_ctrl_t             ctrl,
  input  logic                             active,
  input  logic                             fwd_in,
  input  logic [sshp_pkg::COUNT_WIDTH-1:0] count_in,
  output logic                             fwd,
  output logic [sshp_pkg::COUNT_WIDTH-1:0] count
);

  logic hit;

  assign hit = ctrl.sample && active && (fwd ^ ctrl.rev) && (count != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd   <= 1'b0;
      count <= '0;
    end else begin
      if (ctrl.clr_line) begin
        fwd <= 1'b0;
      end else if (ctrl.sample) begin
        fwd <= fwd_in;
      end
      if (ctrl.clr_count) begin
        count <= '0;
      end else if (ctrl.rotate) begin
        count <= count_in;
      end else if (hit) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sshp_scan.sv -----
// ----------------------------------------------------------------------------
// sshp_scan
// Profile scanner: takes one counter per cycle in index order and tracks
// the phantom minimum, fragment minimum and maximum, and the read point.
// ----------------------------------------------------------------------------
module sshp_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  sshp_pkg::scan_ctrl_t             ctrl,
  input  logic [sshp_pkg::COUNT_WIDTH-1:0] value,
  output sshp_pkg::scan_res_t              res
);

  logic                       finit;
  logic [sshp_pkg::POS_W-1:0] iv;
  logic                       in_frag;
  logic                       in_phan;

  always_comb begin
    iv      = sshp_pkg::POS_W'(ctrl.idx);
    in_frag = (iv >= ctrl.lo && iv <= ctrl.last) || (iv == ctrl.last);
    in_phan = (iv != '0) && (iv <= ctrl.pend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finit <= 1'b0;
    end else if (ctrl.clear) begin
      finit <= 1'b0;
    end else if (ctrl.step && in_frag) begin
      finit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      res.curve <= '0;
      res.fi    <= '0;
      res.pi    <= '0;
    end else if (ctrl.step) begin
      if (in_frag && (!finit || value <= res.fmin)) begin
        res.fmin <= value;
        res.fi   <= ctrl.idx;
      end
      if (in_frag && (!finit || value > res.fmax)) begin
        res.fmax <= value;
      end
      if (iv == '0) begin
        res.pmin <= value;
        res.pi   <= ctrl.idx;
      end else if (in_phan && value < res.pmin) begin
        res.pmin <= value;
        res.pi   <= ctrl.idx;
      end
      if (iv == ctrl.read_idx) begin
        res.curve <= value;
      end
    end
  end

endmodule

// ----- rtl/strand_shift_hamming_profile_core.sv -----
// ----------------------------------------------------------------------------
// strand_shift_hamming_profile_core
// Strand cross-correlation profile over a row of shift cells, with a
// report scan for phantom peak and fragment length.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  op, fwd_hit, rev_hit, step_index
//   out      output     out_valid / out_stall  lengths, distances, curve, error
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// Sample, new chromosome and clear ops do not start a scan.
// Report and read rotate the counter ring once, feeding one counter per
// cycle into the scanner, and then load the output register (later while
// out_stall holds a previous result).
// rst is synchronous, clears the delay line and the counters and loads the
// default config.
// in_stall is high while a scan runs or its result waits for the output.
// ----------------------------------------------------------------------------
module strand_shift_hamming_profile_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       op,
  input  logic                             fwd_hit,
  input  logic                             rev_hit,
  input  logic [sshp_pkg::SIDX_W-1:0]      step_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sshp_pkg::LEN_W-1:0]       fragment_length,
  output logic [sshp_pkg::LEN_W-1:0]       phantom_shift,
  output logic [sshp_pkg::OUT_W-1:0]       distance_at_fragment,
  output logic [sshp_pkg::OUT_W-1:0]       distance_at_phantom,
  output logic [sshp_pkg::OUT_W-1:0]       max_distance,
  output logic [sshp_pkg::OUT_W-1:0]       curve_value,
  output logic                             config_error,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [sshp_pkg::CFG_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  localparam int N = sshp_pkg::MAX_STEPS;

  state_t                         state;
  logic [sshp_pkg::LEN_W-1:0]     steps_used;
  logic [sshp_pkg::RL_W-1:0]      read_length;
  logic [sshp_pkg::IDX_W-1:0]     scan_idx;
  logic                           is_read;
  logic [sshp_pkg::POS_W-1:0]     read_idx;

  logic                           accept;
  logic                           out_free;
  logic [sshp_pkg::POS_W-1:0]     s_eff;
  logic [sshp_pkg::POS_W-1:0]     last;
  logic [sshp_pkg::POS_W-1:0]     lo;
  logic [sshp_pkg::POS_W-1:0]     pend2;
  logic [sshp_pkg::POS_W-1:0]     frag_len;
  logic [sshp_pkg::POS_W-1:0]     phan_len;

  sshp_pkg::cell_ctrl_t           cctrl;
  sshp_pkg::scan_ctrl_t           sctrl;
  sshp_pkg::scan_res_t            sres;

  logic                           fwd_vec [N];
  logic [sshp_pkg::COUNT_WIDTH-1:0] count_vec [N];

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (steps_used == '0) begin
      s_eff = sshp_pkg::POS_W'(1);
    end else if (sshp_pkg::POS_W'(steps_used) > sshp_pkg::POS_W'(N)) begin
      s_eff = sshp_pkg::POS_W'(N);
    end else begin
      s_eff = sshp_pkg::POS_W'(steps_used);
    end
    last  = s_eff - 1'b1;
    lo    = sshp_pkg::POS_W'({read_length, 1'b1});
    pend2 = sshp_pkg::POS_W'({read_length, 1'b0});
  end

  always_comb begin
    cctrl           = '0;
    cctrl.rev       = rev_hit;
    cctrl.rotate    = (state == ST_SCAN);
    if (accept) begin
      case (sshp_pkg::op_t'(op))
        sshp_pkg::OP_SAMPLE:    cctrl.sample    = 1'b1;
        sshp_pkg::OP_NEW_CHROM: cctrl.clr_line  = 1'b1;
        sshp_pkg::OP_CLEAR:     cctrl.clr_count = 1'b1;
        default:                cctrl.sample    = 1'b0;
      endcase
    end
  end

  always_comb begin
    sctrl.clear    = accept && ((sshp_pkg::op_t'(op) == sshp_pkg::OP_REPORT) ||
                                (sshp_pkg::op_t'(op) == sshp_pkg::OP_READ));
    sctrl.step     = (state == ST_SCAN);
    sctrl.idx      = scan_idx;
    sctrl.last     = last;
    sctrl.lo       = lo;
    sctrl.pend     = (pend2 > last) ? last : pend2;
    sctrl.read_idx = read_idx;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic active;
    logic fwd_in;
    assign active = (sshp_pkg::POS_W'(k) < s_eff);
    if (k == 0) begin : g_head
      assign fwd_in = fwd_hit;
    end else begin : g_body
      assign fwd_in = fwd_vec[k-1];
    end
    sshp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cctrl),
      .active   (active),
      .fwd_in   (fwd_in),
      .count_in (count_vec[(k + 1) % N]),
      .fwd      (fwd_vec[k]),
      .count    (count_vec[k])
    );
  end

  sshp_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (sctrl),
    .value (count_vec[0]),
    .res   (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_used  <= sshp_pkg::LEN_W'(512);
      read_length <= sshp_pkg::RL_W'(36);
    end else if (cfg_we) begin
      case (cfg_index)
        sshp_pkg::CFG_STEPS_USED: steps_used  <= cfg_data;
        sshp_pkg::CFG_READ_LEN:   read_length <= cfg_data[sshp_pkg::RL_W-1:0];
        default:                  read_length <= read_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sctrl.clear) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx == sshp_pkg::IDX_W'(N - 1)) begin
            scan_idx <= '0;
            state    <= ST_FINISH;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sctrl.clear) begin
      is_read  <= (sshp_pkg::op_t'(op) == sshp_pkg::OP_READ);
      read_idx <= sshp_pkg::POS_W'(step_index);
    end
  end

  assign frag_len = sshp_pkg::POS_W'(sres.fi) + 1'b1;
  assign phan_len = sshp_pkg::POS_W'(sres.pi) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      if (is_read) begin
        fragment_length      <= '0;
        phantom_shift        <= '0;
        distance_at_fragment <= '0;
        distance_at_phantom  <= '0;
        max_distance         <= '0;
        config_error         <= 1'b0;
        curve_value          <= sshp_pkg::sat_out(sres.curve);
      end else begin
        fragment_length      <= frag_len[sshp_pkg::LEN_W-1:0];
        phantom_shift        <= phan_len[sshp_pkg::LEN_W-1:0];
        distance_at_fragment <= sshp_pkg::sat_out(sres.fmin);
        distance_at_phantom  <= sshp_pkg::sat_out(sres.pmin);
        max_distance         <= sshp_pkg::sat_out(sres.fmax);
        config_error         <= (lo > last);
        curve_value          <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (scan_idx == '0))
    else $error("scan index not parked while idle");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_idx == sshp_pkg::IDX_W'(N - 1)) |=> (state == ST_FINISH))
    else $error("scan did not finish after a full ring rotation");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished scan did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(curve_value) &&
                                  $stable(fragment_length)))
    else $error("waiting result overwritten");
`endif

endmodule
